### hdl/gtrm_pkg.sv
package gtrm_pkg;

    // Pattern capacity and the widths that follow from it
    localparam int MAX_TOKENS = 16;
    localparam int PTR_W      = $clog2(MAX_TOKENS + 1);

    // Fixed field widths of the request
    localparam int LEN_W  = 5;
    localparam int SLOT_W = 4;
    localparam int CHAR_W = 8;
    localparam int WORD_W = 64;
    localparam int SET_W  = 256;

    // Packed input tdata layout, lowest field first
    localparam int TD_SLOT_LSB  = 0;
    localparam int TD_SORT_LSB  = TD_SLOT_LSB + SLOT_W;
    localparam int TD_QUANT_LSB = TD_SORT_LSB + 2;
    localparam int TD_LIT_LSB   = TD_QUANT_LSB + 2;
    localparam int TD_SWI_LSB   = TD_LIT_LSB + CHAR_W;
    localparam int TD_WORD_LSB  = TD_SWI_LSB + 2;
    localparam int TD_CHAR_LSB  = TD_WORD_LSB + WORD_W;
    localparam int TD_IN_W      = 96;
    localparam int TD_OUT_W     = 8;

    // Token kind codes; the fourth code matches nothing
    localparam logic [1:0] KIND_ANY = 2'd0;
    localparam logic [1:0] KIND_LIT = 2'd1;
    localparam logic [1:0] KIND_SET = 2'd2;

    typedef enum logic [1:0] {
        CMD_HDR  = 2'd0,
        CMD_SET  = 2'd1,
        CMD_CHAR = 2'd2,
        CMD_END  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        Q_ONCE = 2'd0,
        Q_STAR = 2'd1,
        Q_PLUS = 2'd2,
        Q_OPT  = 2'd3
    } t_quant;

    // Pattern write broadcast to every cell
    typedef struct packed {
        logic                hdr_we;
        logic                set_we;
        logic [SLOT_W-1:0]   slot;
        logic [1:0]          kind;
        t_quant              quant;
        logic [CHAR_W-1:0]   lit;
        logic [1:0]          swi;
        logic [WORD_W-1:0]   word;
    } t_wr;

    // Skip chain link handed from one cell to the next
    typedef struct packed {
        logic walk;
        logic ps;
    } t_link;

    // Per-cell verdict for the current character and for end of string
    typedef struct packed {
        logic             stop;
        logic             fail;
        logic [PTR_W-1:0] next_ptr;
        logic             next_ps;
    } t_cell_res;

endpackage

### hdl/gtrm_cell.sv
module gtrm_cell
    import gtrm_pkg::*;
(
    input  logic              i_clk,
    input  logic [PTR_W-1:0]  i_index,
    input  t_wr               i_wr,
    input  logic [CHAR_W-1:0] i_char,
    input  logic [PTR_W-1:0]  i_len,
    input  logic [PTR_W-1:0]  i_ptr,
    input  logic              i_ps,
    input  t_link             i_link,
    input  logic              i_next_takes,
    output t_link             o_link,
    output logic              o_takes,
    output t_cell_res         o_res
);

    logic [1:0]        r_kind;
    t_quant            r_quant;
    logic [CHAR_W-1:0] r_lit;
    logic [SET_W-1:0]  r_set;

    logic w_sel;
    logic w_hit;
    logic w_here;
    logic w_act;
    logic w_ps;
    logic w_range;
    logic w_skip;
    logic w_stop;
    logic w_ok_end;

    assign w_sel = (32'(i_wr.slot) == 32'(i_index));

    // Token storage, no reset: contents are undefined until written
    always_ff @(posedge i_clk) begin
        if (i_wr.hdr_we && w_sel) begin
            r_kind  <= i_wr.kind;
            r_quant <= i_wr.quant;
            r_lit   <= i_wr.lit;
        end
        if (i_wr.set_we && w_sel) begin
            r_set[{i_wr.swi, 6'd0} +: WORD_W] <= i_wr.word;
        end
    end

    always_comb begin
        unique case (r_kind)
            KIND_ANY: w_hit = 1'b1;
            KIND_LIT: w_hit = (r_lit == i_char);
            KIND_SET: w_hit = r_set[i_char];
            default:  w_hit = 1'b0;
        endcase
    end

    assign w_here  = (i_ptr == i_index);
    assign w_act   = w_here | i_link.walk;
    assign w_ps    = w_here ? i_ps : i_link.ps;
    assign w_range = (i_index < i_len);
    assign o_takes = w_range && (r_quant == Q_ONCE) && w_hit;

    // End of string: every token from the pointer on must be skippable
    assign w_ok_end = (r_quant == Q_STAR) || (r_quant == Q_OPT) ||
                      ((r_quant == Q_PLUS) && w_here && i_ps);

    // Decide whether the walk stops here, passes on, or dies
    always_comb begin
        w_stop           = 1'b0;
        w_skip           = 1'b0;
        o_res.next_ptr   = i_index;
        o_res.next_ps    = w_ps;
        unique case (r_quant)
            Q_ONCE: begin
                w_stop         = w_hit;
                o_res.next_ptr = i_index + PTR_W'(1);
            end
            Q_STAR: begin
                w_stop = w_hit;
                w_skip = !w_hit;
            end
            Q_PLUS: begin
                w_stop        = w_hit;
                w_skip        = !w_hit && w_ps;
                o_res.next_ps = 1'b1;
            end
            Q_OPT: begin
                w_stop         = w_hit && !i_next_takes;
                w_skip         = !w_stop;
                o_res.next_ptr = i_index + PTR_W'(1);
            end
            default: ;
        endcase
        o_res.stop = w_act && w_range && w_stop;
        o_res.fail = w_range && (i_index >= i_ptr) && !w_ok_end;
    end

    assign o_link.walk = w_act && w_range && w_skip;
    assign o_link.ps   = (r_quant == Q_PLUS) ? 1'b0 : w_ps;

endmodule

### hdl/greedy_token_regex_matcher_core.sv
// Greedy token matcher: a pattern of up to MAX_TOKENS tokens (any character,
// literal, or 256-bit class set, each with once/star/plus/optional) is loaded
// by header and class-word requests, then text streams one character per
// request. Matching is greedy and never backtracks. A new request is
// accepted every clock unless input is held off, as below: each token lives in a
// cell of a row, and the cells hand a skip link to their neighbor, so star,
// optional and satisfied-plus skips across the whole row resolve within the
// cycle the character arrives. An end-of-string request yields one result
// (matched flag) through an output register and rearms the matcher at once;
// input is held off only while that register is full and not being taken. The
// user writes pattern_length when idle (not enforced); it is clamped to MAX_TOKENS.
module greedy_token_regex_matcher_core
    import gtrm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration: pattern_length
    input  logic                i_cfg_we,
    input  logic [LEN_W-1:0]    i_cfg_wdata,
    // Request stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata: token_slot[3:0], token_sort[5:4], quantifier[7:6], literal[15:8],
    //        set_word_index[17:16], set_word[81:18], text_char[89:82], zeros
    input  logic [TD_IN_W-1:0]  s_axis_tdata,
    // tuser: command[1:0]
    input  logic [1:0]          s_axis_tuser,
    // Result stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata: matched[0], zeros
    output logic [TD_OUT_W-1:0] m_axis_tdata
);

    // Control state
    logic [LEN_W-1:0] r_len_cfg;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic             r_ps, n_ps;
    logic             r_mism, n_mism;
    logic             r_out_valid, n_out_valid;
    logic             r_matched, n_matched;

    logic             w_acc;
    t_cmd             w_cmd;
    logic [CHAR_W-1:0] w_char;
    logic [PTR_W-1:0] w_len;
    t_wr              w_wr;

    t_link            w_link  [MAX_TOKENS+1];
    logic             w_takes [MAX_TOKENS+1];
    t_cell_res        w_res   [MAX_TOKENS];
    logic [MAX_TOKENS-1:0] w_stop_vec;

    logic             w_any_stop;
    logic             w_any_fail;
    logic [PTR_W-1:0] w_stop_ptr;
    logic             w_stop_ps;

    // Accept while the result register has room or is draining
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_cmd         = t_cmd'(s_axis_tuser);
    assign w_char        = s_axis_tdata[TD_CHAR_LSB +: CHAR_W];

    // Clamp the stored length to the pattern capacity
    assign w_len = (32'(r_len_cfg) > 32'(MAX_TOKENS)) ? PTR_W'(MAX_TOKENS)
                                                      : PTR_W'(r_len_cfg);

    always_comb begin
        w_wr.hdr_we = w_acc && (w_cmd == CMD_HDR);
        w_wr.set_we = w_acc && (w_cmd == CMD_SET);
        w_wr.slot   = s_axis_tdata[TD_SLOT_LSB +: SLOT_W];
        w_wr.kind   = s_axis_tdata[TD_SORT_LSB +: 2];
        w_wr.quant  = t_quant'(s_axis_tdata[TD_QUANT_LSB +: 2]);
        w_wr.lit    = s_axis_tdata[TD_LIT_LSB +: CHAR_W];
        w_wr.swi    = s_axis_tdata[TD_SWI_LSB +: 2];
        w_wr.word   = s_axis_tdata[TD_WORD_LSB +: WORD_W];
    end

    // Row of token cells; the walk enters at the pointer and moves upward
    assign w_link[0]           = '{walk: 1'b0, ps: 1'b0};
    assign w_takes[MAX_TOKENS] = 1'b0;

    for (genvar g = 0; g < MAX_TOKENS; g++) begin : g_cell
        gtrm_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (PTR_W'(g)),
            .i_wr         (w_wr),
            .i_char       (w_char),
            .i_len        (w_len),
            .i_ptr        (r_ptr),
            .i_ps         (r_ps),
            .i_link       (w_link[g]),
            .i_next_takes (w_takes[g+1]),
            .o_link       (w_link[g+1]),
            .o_takes      (w_takes[g]),
            .o_res        (w_res[g])
        );
        assign w_stop_vec[g] = w_res[g].stop;
    end

    // Gather the single stopping cell's update and any end-of-string failure
    always_comb begin
        w_any_stop = 1'b0;
        w_any_fail = 1'b0;
        w_stop_ptr = '0;
        w_stop_ps  = 1'b0;
        for (int i = 0; i < MAX_TOKENS; i++) begin
            w_any_stop = w_any_stop | w_res[i].stop;
            w_any_fail = w_any_fail | w_res[i].fail;
            w_stop_ptr = w_stop_ptr | (w_res[i].next_ptr & {PTR_W{w_res[i].stop}});
            w_stop_ps  = w_stop_ps  | (w_res[i].next_ps & w_res[i].stop);
        end
    end

    // Next-state logic
    always_comb begin
        n_ptr       = r_ptr;
        n_ps        = r_ps;
        n_mism      = r_mism;
        n_matched   = r_matched;
        n_out_valid = r_out_valid && !m_axis_tready;
        if (w_acc) begin
            unique case (w_cmd)
                CMD_CHAR: begin
                    // Drop characters once the string has failed
                    if (!r_mism) begin
                        if (w_any_stop) begin
                            n_ptr = w_stop_ptr;
                            n_ps  = w_stop_ps;
                        end else begin
                            n_mism = 1'b1;
                        end
                    end
                end
                CMD_END: begin
                    n_matched   = !r_mism && !w_any_fail;
                    n_out_valid = 1'b1;
                    n_ptr       = '0;
                    n_ps        = 1'b0;
                    n_mism      = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg   <= '0;
            r_ptr       <= '0;
            r_ps        <= 1'b0;
            r_mism      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len_cfg <= i_cfg_wdata;
            end
            r_ptr       <= n_ptr;
            r_ps        <= n_ps;
            r_mism      <= n_mism;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload holds no reset
    always_ff @(posedge i_clk) begin
        r_matched <= n_matched;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TD_OUT_W-1){1'b0}}, r_matched};

    // The skip walk ends in at most one cell
    a_one_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_stop_vec))
        else $error("more than one token cell claimed the character");

    // End of string rearms the matcher and posts a result
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_cmd == CMD_END)) |=> (r_ptr == '0) && !r_ps && !r_mism && r_out_valid)
        else $error("matcher not rearmed after end of string");

    // The pointer never runs past the pattern capacity
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ptr) <= 32'(MAX_TOKENS))
        else $error("token pointer beyond capacity");

    // A failed string stays failed until its end
    a_mism_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mism && !(w_acc && (w_cmd == CMD_END))) |=> r_mism)
        else $error("mismatch flag cleared before end of string");

endmodule

### sim/tb.sv
module tb;
    import gtrm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Kind code with no name in the package: such a token matches nothing
    localparam logic [1:0] KIND_NONE = 2'd3;

    // Idle patterns, one per stage of the run
    localparam int IDLE_SEND_LIGHT = 0;  // sender 18 %, receiver 71 %
    localparam int IDLE_SEND_HEAVY = 1;  // sender 71 %, receiver 18 %
    localparam int IDLE_NONE       = 2;

    // One request as the sender sees it; drain marks a pause, not a request
    typedef struct {
        t_cmd              cmd;
        logic [SLOT_W-1:0] slot;
        logic [1:0]        kind;
        t_quant            quant;
        logic [CHAR_W-1:0] lit;
        logic [1:0]        swi;
        logic [WORD_W-1:0] word;
        logic [CHAR_W-1:0] ch;
        bit                drain;
    } t_text_req;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [LEN_W-1:0]    i_cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // tdata: token_slot[3:0], token_sort[5:4], quantifier[7:6], literal[15:8],
    //        set_word_index[17:16], set_word[81:18], text_char[89:82], zeros
    logic [TD_IN_W-1:0]  s_axis_tdata = '0;
    // tuser: command[1:0]
    logic [1:0]          s_axis_tuser = 2'd0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // tdata: matched[0], zeros
    logic [TD_OUT_W-1:0] m_axis_tdata;

    greedy_token_regex_matcher_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Matcher prediction: pattern tables, length and string progress,
    // advanced once per accepted request.
    // ------------------------------------------------------------------
    logic [1:0]        tok_kind [MAX_TOKENS];
    t_quant            tok_quant[MAX_TOKENS];
    logic [CHAR_W-1:0] tok_lit  [MAX_TOKENS];
    logic [WORD_W-1:0] tok_set  [MAX_TOKENS*4];
    logic [LEN_W-1:0]  model_len = '0;
    int unsigned       cur_tok = 0;
    bit                plus_met = 1'b0;
    bit                str_failed = 1'b0;

    // Match flags still owed by the block, oldest first
    bit                match_due[$];

    function automatic int unsigned active_len();
        return (model_len > MAX_TOKENS) ? MAX_TOKENS : model_len;
    endfunction

    function automatic bit token_takes(int unsigned t, logic [CHAR_W-1:0] c);
        case (tok_kind[t])
            KIND_ANY: return 1'b1;
            KIND_LIT: return tok_lit[t] == c;
            KIND_SET: return tok_set[t*4 + c[7:6]][c[5:0]];
            default:  return 1'b0;
        endcase
    endfunction

    // Consume one character greedily; skips across star, optional and
    // satisfied plus tokens resolve within the same character.
    function automatic void feed_char(logic [CHAR_W-1:0] c);
        int unsigned lim;
        int unsigned t;
        bit hit;
        bit next_takes;
        lim = active_len();
        t = cur_tok;
        while (1) begin
            if (t >= lim) begin
                str_failed = 1'b1;
                return;
            end
            hit = token_takes(t, c);
            case (tok_quant[t])
                Q_ONCE: begin
                    if (!hit) str_failed = 1'b1;
                    else cur_tok = t + 1;
                    return;
                end
                Q_STAR: begin
                    if (hit) begin
                        cur_tok = t;
                        return;
                    end
                    t++;
                end
                Q_PLUS: begin
                    if (hit) begin
                        cur_tok = t;
                        plus_met = 1'b1;
                        return;
                    end
                    if (!plus_met) begin
                        str_failed = 1'b1;
                        return;
                    end
                    plus_met = 1'b0;
                    t++;
                end
                default: begin
                    // Optional: yield the character to an unquantified
                    // next token that would take it too
                    if (hit) begin
                        next_takes = (t + 1 < lim) && (tok_quant[t+1] == Q_ONCE) &&
                                     token_takes(t + 1, c);
                        if (!next_takes) begin
                            cur_tok = t + 1;
                            return;
                        end
                    end
                    t++;
                end
            endcase
        end
    endfunction

    // At end of string every token left must be skippable
    function automatic bit string_ok();
        int unsigned t;
        if (str_failed) return 1'b0;
        for (t = cur_tok; t < active_len(); t++) begin
            if (tok_quant[t] == Q_STAR || tok_quant[t] == Q_OPT) continue;
            if (tok_quant[t] == Q_PLUS && t == cur_tok && plus_met) continue;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void advance_matcher(t_text_req r);
        case (r.cmd)
            CMD_HDR: begin
                tok_kind[r.slot]  = r.kind;
                tok_quant[r.slot] = r.quant;
                tok_lit[r.slot]   = r.lit;
            end
            CMD_SET: tok_set[{r.slot, r.swi}] = r.word;
            CMD_CHAR: if (!str_failed) feed_char(r.ch);
            default: begin
                match_due.insert(match_due.size(), string_ok());
                cur_tok    = 0;
                plus_met   = 1'b0;
                str_failed = 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus side: its own view of the pattern, used only to build
    // strings that get deep into the pattern.
    // ------------------------------------------------------------------
    t_text_req         pending[$];
    logic [1:0]        gen_kind [MAX_TOKENS];
    t_quant            gen_quant[MAX_TOKENS];
    logic [CHAR_W-1:0] gen_lit  [MAX_TOKENS];
    logic [WORD_W-1:0] gen_set  [MAX_TOKENS*4];
    logic [LEN_W-1:0]  gen_cfg = '0;
    int                queued = 0;
    int                idle_mode = IDLE_SEND_LIGHT;
    int                err_count = 0;

    function automatic int gen_len();
        return (gen_cfg > MAX_TOKENS) ? MAX_TOKENS : gen_cfg;
    endfunction

    // Random filler in every field, so unused fields toggle too
    function automatic t_text_req rand_req(t_cmd cmd);
        t_text_req r;
        r.cmd   = cmd;
        r.slot  = SLOT_W'($urandom);
        r.kind  = 2'($urandom);
        r.quant = t_quant'($urandom_range(0, 3));
        r.lit   = CHAR_W'($urandom);
        r.swi   = 2'($urandom);
        r.word  = {$urandom, $urandom};
        r.ch    = CHAR_W'($urandom);
        r.drain = 1'b0;
        return r;
    endfunction

    function automatic void queue_req(t_text_req r);
        if (r.cmd == CMD_HDR) begin
            gen_kind[r.slot]  = r.kind;
            gen_quant[r.slot] = r.quant;
            gen_lit[r.slot]   = r.lit;
        end else if (r.cmd == CMD_SET) begin
            gen_set[{r.slot, r.swi}] = r.word;
        end
        pending.insert(pending.size(), r);
        queued++;
    endfunction

    function automatic void queue_hdr(int slot, logic [1:0] kind, t_quant quant,
                                      logic [CHAR_W-1:0] lit);
        t_text_req r;
        r = rand_req(CMD_HDR);
        r.slot  = SLOT_W'(slot);
        r.kind  = kind;
        r.quant = quant;
        r.lit   = lit;
        queue_req(r);
    endfunction

    function automatic void queue_word(int slot, int idx, logic [WORD_W-1:0] word);
        t_text_req r;
        r = rand_req(CMD_SET);
        r.slot = SLOT_W'(slot);
        r.swi  = 2'(idx);
        r.word = word;
        queue_req(r);
    endfunction

    function automatic void queue_char(logic [CHAR_W-1:0] c);
        t_text_req r;
        r = rand_req(CMD_CHAR);
        r.ch = c;
        queue_req(r);
    endfunction

    function automatic void queue_end();
        queue_req(rand_req(CMD_END));
    endfunction

    // Hold the sender until every owed match flag has come back
    function automatic void queue_drain();
        t_text_req r;
        r = rand_req(CMD_END);
        r.drain = 1'b1;
        pending.insert(pending.size(), r);
    endfunction

    function automatic logic [1:0] pick_kind();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 3) return KIND_ANY;
        if (roll == 3) return KIND_NONE;
        if (roll < 13) return KIND_LIT;
        return KIND_SET;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 3))
            0:       return '1;
            1:       return {$urandom, $urandom} & {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // A character the token would take, or a random one if none exists
    function automatic logic [CHAR_W-1:0] char_for(int t);
        logic [CHAR_W-1:0] c;
        int k;
        c = CHAR_W'($urandom);
        if (gen_kind[t] == KIND_LIT) begin
            c = gen_lit[t];
        end else if (gen_kind[t] == KIND_SET) begin
            for (k = 0; k < 256; k++) begin
                if (gen_set[t*4 + c[7:6]][c[5:0]]) return c;
                c++;
            end
        end
        return c;
    endfunction

    function automatic void load_pattern();
        int t;
        int w;
        for (t = 0; t < gen_len(); t++) begin
            queue_hdr(t, pick_kind(), t_quant'($urandom_range(0, 3)), CHAR_W'($urandom));
            if (gen_kind[t] == KIND_SET && $urandom_range(0, 1) == 0) begin
                for (w = 0; w < 4; w++) queue_word(t, w, pick_word());
            end
        end
    endfunction

    // Walk the pattern token by token with characters that fit, with the
    // odd stray character, early stop or pattern rewrite thrown in.
    function automatic void queue_string(bit well_formed);
        int t;
        int n;
        int reps;
        t_text_req r;
        if (well_formed) begin
            for (t = 0; t < gen_len(); t++) begin
                case (gen_quant[t])
                    Q_ONCE:  reps = 1;
                    Q_STAR:  reps = $urandom_range(0, 3);
                    Q_PLUS:  reps = $urandom_range(1, 3);
                    default: reps = $urandom_range(0, 1);
                endcase
                for (n = 0; n < reps; n++) begin
                    if ($urandom_range(0, 39) == 0) queue_char(CHAR_W'($urandom));
                    queue_char(char_for(t));
                end
                if ($urandom_range(0, 49) == 0) begin
                    r = rand_req(CMD_HDR);
                    queue_req(r);
                end
                if ($urandom_range(0, 29) == 0) break;
            end
        end else begin
            reps = $urandom_range(0, 6);
            for (n = 0; n < reps; n++) begin
                if ($urandom_range(0, 1) == 0) queue_char(CHAR_W'($urandom));
                else queue_char(char_for($urandom_range(0, MAX_TOKENS - 1)));
            end
        end
        queue_end();
    endfunction

    function automatic void report_error(string what, bit exp, logic act);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s: expected matched=%0b, got %b", $time, what, exp, act);
    endfunction

    // Random idling, with a recurring quiet window in which neither side idles
    function automatic bit side_idles(bit is_sender);
        int pct;
        if ((($time / 10) % 300) < 50) return 1'b0;
        case (idle_mode)
            IDLE_SEND_LIGHT: pct = is_sender ? 18 : 71;
            IDLE_SEND_HEAVY: pct = is_sender ? 71 : 18;
            default:         pct = 0;
        endcase
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [TD_IN_W-1:0] pack_request(t_text_req r);
        logic [TD_IN_W-1:0] d;
        d = '0;
        d[TD_SLOT_LSB  +: SLOT_W] = r.slot;
        d[TD_SORT_LSB  +: 2]      = r.kind;
        d[TD_QUANT_LSB +: 2]      = r.quant;
        d[TD_LIT_LSB   +: CHAR_W] = r.lit;
        d[TD_SWI_LSB   +: 2]      = r.swi;
        d[TD_WORD_LSB  +: WORD_W] = r.word;
        d[TD_CHAR_LSB  +: CHAR_W] = r.ch;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Driver: predict each request at the edge that accepts it, then
    // present the next one from the pending queue.
    // ------------------------------------------------------------------
    t_text_req cur_req;

    always @(posedge i_clk) begin : drive_requests
        bit go;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) advance_matcher(cur_req);
            go = pending.size() > 0 && !side_idles(1'b1);
            // Drop a drain marker only once nothing is owed any more
            if (go && pending[0].drain) begin
                if (match_due.size() == 0) void'(pending.pop_front());
                go = 1'b0;
            end
            if (go) begin
                cur_req = pending.pop_front();
                s_axis_tdata <= pack_request(cur_req);
                s_axis_tuser <= cur_req.cmd;
            end
            s_axis_tvalid <= go;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted match flag against the oldest one owed.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_results
        bit exp;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                if (match_due.size() == 0) begin
                    report_error("result with none owed", 1'b0, m_axis_tdata[0]);
                end else begin
                    exp = match_due.pop_front();
                    if (m_axis_tdata[0] !== exp)
                        report_error("wrong match flag", exp, m_axis_tdata[0]);
                end
            end
            m_axis_tready <= !side_idles(1'b0);
        end
    end

    // Block until no request is waiting or in flight and nothing is owed,
    // then allow for a string left open inside the block
    task automatic wait_idle();
        while (pending.size() != 0 || s_axis_tvalid || match_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_length(logic [LEN_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        model_len = v;
        gen_cfg   = v;
    endtask

    initial begin : stimulus
        int s;
        int w;
        int ph;
        int roll;
        int target;
        logic [LEN_W-1:0] ph_len[6];

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty pattern: an empty string matches, any character fails it
        write_length(5'd0);
        queue_end();
        queue_char(8'h00);
        queue_end();

        // Fill every slot so no string ever reads an unwritten entry
        for (s = 0; s < MAX_TOKENS; s++) begin
            queue_hdr(s, pick_kind(), t_quant'($urandom_range(0, 3)), CHAR_W'($urandom));
            for (w = 0; w < 4; w++) queue_word(s, w, pick_word());
        end
        wait_idle();

        // a+ [class]? b
        write_length(5'd3);
        queue_hdr(0, KIND_LIT, Q_PLUS, "a");
        queue_hdr(1, KIND_SET, Q_OPT, 8'h00);
        queue_hdr(2, KIND_LIT, Q_ONCE, "b");
        queue_word(1, 0, '0);
        queue_word(1, 1, '1);
        queue_word(1, 2, '0);
        queue_word(1, 3, 64'h8000_0000_0000_0000);
        // optional yields 'b' to the literal after it
        queue_char("a");
        queue_char("a");
        queue_char("b");
        queue_end();
        // satisfied plus at end, but the literal is still owed
        queue_char("a");
        queue_end();
        // class takes 8'hFF, then a character past the last token, then one
        // after the mismatch
        queue_char("a");
        queue_char(8'hFF);
        queue_char("b");
        queue_char("z");
        queue_char("q");
        queue_end();
        // rewrite the middle token mid-string to a star that matches nothing
        queue_char("a");
        queue_hdr(1, KIND_NONE, Q_STAR, 8'h00);
        queue_char("b");
        queue_end();
        wait_idle();

        // Length beyond capacity acts as full capacity
        write_length(5'd31);
        queue_string(1'b1);
        queue_string(1'b1);
        queue_string(1'b0);
        wait_idle();

        // Random phases; two per idle pattern
        ph_len[0] = 5'd16;
        ph_len[1] = 5'd1;
        ph_len[2] = LEN_W'($urandom_range(2, 15));
        ph_len[3] = 5'd31;
        ph_len[4] = LEN_W'($urandom_range(0, 31));
        ph_len[5] = LEN_W'($urandom_range(4, 16));
        for (ph = 0; ph < 6; ph++) begin
            idle_mode = ph / 2;
            write_length(ph_len[ph]);
            target = queued + 85;
            load_pattern();
            while (queued < target) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    queue_string(1'b1);
                end else if (roll < 85) begin
                    queue_string(1'b0);
                end else if (roll < 95) begin
                    queue_hdr($urandom_range(0, MAX_TOKENS - 1), pick_kind(),
                              t_quant'($urandom_range(0, 3)), CHAR_W'($urandom));
                end else begin
                    queue_word($urandom_range(0, MAX_TOKENS - 1), $urandom_range(0, 3),
                               pick_word());
                end
                if ($urandom_range(0, 19) == 0) queue_drain();
            end
            queue_drain();
            queue_string(1'b1);
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run
    initial begin : watchdog
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### greedy_token_regex_matcher_core.f
hdl/gtrm_pkg.sv
hdl/gtrm_cell.sv
hdl/greedy_token_regex_matcher_core.sv
sim/tb.sv
